@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");

`endif

@@ sv/wesm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder speed meter package
// Widths, constants, direction and configuration codes and the job record between front and back.
// ----------------------------------------------------------------------------
package wesm_pkg;

	localparam int TICK_COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH         = 4;

	localparam int TICKS_W = 32;
	localparam int P_W     = 16;
	localparam int D_W     = 12;
	localparam int TIME_W  = 32;
	localparam int DIST_W  = 41;
	localparam int VELO_W  = 48;
	localparam int PROD1_W = TICKS_W + D_W;
	localparam int A_W     = PROD1_W + 10;
	localparam int PI_W    = 18;
	localparam int LO_W    = 32 + PI_W;
	localparam int HI_W    = (A_W - 32) + PI_W;
	localparam int S_W     = A_W + PI_W - 16;
	localparam int MAG_W   = DIST_W - 1;
	localparam int VEL_W   = VELO_W - 1;
	localparam int NUM_W   = MAG_W + 20;
	localparam int DEN_W   = TIME_W;

	localparam logic [PI_W-1:0] PI_Q16     = 18'd205887;
	localparam logic [9:0]      MM_TO_UM   = 10'd1000;
	localparam logic [19:0]     US_PER_S   = 20'd1000000;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BWD  = 2'd3;

	localparam logic [1:0] CFG_TICKS_PER_REV = 2'd0;
	localparam logic [1:0] CFG_WHEEL_DIAM    = 2'd1;
	localparam logic [1:0] CFG_INTERVAL      = 2'd2;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic [TIME_W-1:0]  dt;
		logic [1:0]         dir;
		logic [31:0]        total;
	} job_t;

endpackage

@@ sv/wesm_front.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder front end
// Edge detection, window tick count, running total and update timing.
// ----------------------------------------------------------------------------
module wesm_front import wesm_pkg::*; #(
	parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              pin_a,
	input  logic              pin_b,
	input  logic [TIME_W-1:0] time_now_us,
	input  logic [TIME_W-1:0] update_interval_us,
	input  logic              q_full,
	output logic              push,
	output job_t              job
);

	localparam logic [TICK_COUNT_BITS-1:0] TICK_LIMIT = {TICK_COUNT_BITS{1'b1}};

	logic                       prev_a_q;
	logic [1:0]                 dir_q;
	logic [TICK_COUNT_BITS-1:0] wt_q;
	logic [31:0]                run_q;
	logic [TIME_W-1:0]          last_q;
	logic                       started_q;

	logic                       accept;
	logic                       rise;
	logic [1:0]                 dir_n;
	logic [TICK_COUNT_BITS-1:0] wt_n;
	logic [TIME_W-1:0]          dt;
	logic [31:0]                run_n;
	logic                       fire;

	assign in_stall = q_full;

	always_comb begin
		accept = in_valid && !q_full;
		rise   = !prev_a_q && pin_a;
		dir_n  = rise ? (pin_b ? DIR_FWD : DIR_BWD) : dir_q;
		wt_n   = (rise && wt_q != TICK_LIMIT) ? wt_q + 1'b1 : wt_q;
		dt     = time_now_us - last_q;
		fire   = accept && started_q && (dt > update_interval_us);
		case (dir_n)
			DIR_FWD: run_n = run_q + TICKS_W'(wt_n);
			DIR_BWD: run_n = run_q - TICKS_W'(wt_n);
			default: run_n = run_q;
		endcase
		push      = fire;
		job.ticks = TICKS_W'(wt_n);
		job.dt    = dt;
		job.dir   = dir_n;
		job.total = run_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q  <= 1'b0;
			dir_q     <= DIR_NONE;
			wt_q      <= '0;
			run_q     <= '0;
			last_q    <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			prev_a_q <= pin_a;
			dir_q    <= dir_n;
			if (!started_q) begin
				started_q <= 1'b1;
				last_q    <= time_now_us;
				wt_q      <= wt_n;
			end else if (fire) begin
				wt_q   <= '0;
				last_q <= time_now_us;
				run_q  <= run_n;
			end else begin
				wt_q <= wt_n;
			end
		end
	end

endmodule

@@ sv/wesm_queue.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder job queue
// Short first-in first-out store of update jobs between front and back.
// ----------------------------------------------------------------------------
module wesm_queue import wesm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/wesm_div.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wesm_div import wesm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             qbit;
	logic [DEN_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		qbit  = trial >= {1'b0, den_q};
		rem_n = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[NUM_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

@@ sv/wesm_back.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder back end
// Sequencer for distance and velocity arithmetic, with the output register.
// ----------------------------------------------------------------------------
module wesm_back import wesm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [P_W-1:0]    ticks_per_rev,
	input  logic [D_W-1:0]    wheel_diameter_mm,
	input  logic              q_empty,
	input  job_t              head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DIST_W-1:0] window_distance_um,
	output logic [VELO_W-1:0] velocity_um_per_s,
	output logic [31:0]       total_ticks
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_MUL1   = 10'b0000000010,
		S_MUL2   = 10'b0000000100,
		S_MUL3   = 10'b0000001000,
		S_SUM    = 10'b0000010000,
		S_DIV1   = 10'b0000100000,
		S_MUL4   = 10'b0001000000,
		S_VSTART = 10'b0010000000,
		S_DIV2   = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [PROD1_W-1:0] prod1_q;
	logic [A_W-1:0]     a_q;
	logic [LO_W-1:0]    lo_q;
	logic [HI_W-1:0]    hi_q;
	logic [MAG_W-1:0]   mag_q;
	logic [NUM_W-1:0]   vm_q;
	logic [VEL_W-1:0]   velm_q;

	logic               out_valid_q;
	logic [DIST_W-1:0]  dist_q;
	logic [VELO_W-1:0]  vel_q;
	logic [31:0]        total_q;

	logic [S_W-1:0]     s_sum;
	logic [DEN_W-1:0]   p_eff;
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic               out_take;

	wesm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		s_sum     = {hi_q, 16'd0} + S_W'(lo_q[LO_W-1:16]);
		p_eff     = (ticks_per_rev == '0) ? DEN_W'(1) : DEN_W'(ticks_per_rev);
		div_start = (state_q == S_SUM) || (state_q == S_VSTART);
		div_num   = (state_q == S_SUM) ? NUM_W'(s_sum) : vm_q;
		div_den   = (state_q == S_SUM) ? p_eff : job_q.dt;
		pop       = (state_q == S_IDLE) && !q_empty && !out_valid_q;
		out_take  = out_valid_q && !out_stall;
	end

	assign out_valid          = out_valid_q;
	assign window_distance_um = dist_q;
	assign velocity_um_per_s  = vel_q;
	assign total_ticks        = total_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				job_q <= head;
			end
			S_MUL1: begin
				prod1_q <= PROD1_W'(job_q.ticks) * PROD1_W'(wheel_diameter_mm);
			end
			S_MUL2: begin
				a_q <= A_W'(prod1_q) * A_W'(MM_TO_UM);
			end
			S_MUL3: begin
				lo_q <= LO_W'(a_q[31:0]) * LO_W'(PI_Q16);
				hi_q <= HI_W'(a_q[A_W-1:32]) * HI_W'(PI_Q16);
			end
			S_DIV1: begin
				mag_q <= (|div_quo[NUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : div_quo[MAG_W-1:0];
			end
			S_MUL4: begin
				vm_q <= NUM_W'(mag_q) * NUM_W'(US_PER_S);
			end
			S_DIV2: begin
				velm_q <= (|div_quo[NUM_W-1:VEL_W]) ? {VEL_W{1'b1}} : div_quo[VEL_W-1:0];
			end
			S_DONE: begin
				total_q <= job_q.total;
				case (job_q.dir)
					DIR_FWD: begin
						dist_q <= {1'b0, mag_q};
						vel_q  <= {1'b0, velm_q};
					end
					DIR_BWD: begin
						dist_q <= -{1'b0, mag_q};
						vel_q  <= -{1'b0, velm_q};
					end
					default: begin
						dist_q <= '0;
						vel_q  <= '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_MUL3;
				S_MUL3:   state_q <= S_SUM;
				S_SUM:    state_q <= S_DIV1;
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_MUL4;
					end
				end
				S_MUL4:   state_q <= S_VSTART;
				S_VSTART: state_q <= S_DIV2;
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/wheel_encoder_speed_meter_core.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder speed meter
// Quadrature encoder tick counting with windowed distance and velocity.
// ----------------------------------------------------------------------------
// The input channel takes one beat per encoder sample: levels of channels A
// and B and a microsecond timestamp. A beat is taken in every cycle while the
// job queue has room, so samples may stream at full clock rate.
// When the elapsed time since the last update exceeds the update interval,
// the front end queues a job and the output channel later delivers one beat
// holding the window distance, the velocity and the running tick total.
// The back end runs two bit-serial divisions of 60 steps each through one shared
// divider and works on one job at a time: it takes the next job from the queue
// only after the previous result beat has been taken.
// The configuration port writes ticks per revolution, wheel diameter and the
// update interval; the user is to make writes only while no result is
// outstanding, which the block does not enforce. Reset clears all counters,
// the queue and the output valid flag, and loads the default configuration.
// While the receiver stalls, the output beat is held, the back end waits, and
// up to four jobs gather in the queue; after that the input channel stalls.
module wheel_encoder_speed_meter_core import wesm_pkg::*; #(
	parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              pin_a,
	input  logic              pin_b,
	input  logic [TIME_W-1:0] time_now_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DIST_W-1:0] window_distance_um,
	output logic [VELO_W-1:0] velocity_um_per_s,
	output logic [31:0]       total_ticks
);

	logic [P_W-1:0]    ticks_per_rev_q;
	logic [D_W-1:0]    wheel_diameter_q;
	logic [TIME_W-1:0] interval_q;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_rev_q  <= P_W'(20);
			wheel_diameter_q <= D_W'(65);
			interval_q       <= TIME_W'(100000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICKS_PER_REV: ticks_per_rev_q  <= cfg_wdata[P_W-1:0];
				CFG_WHEEL_DIAM:    wheel_diameter_q <= cfg_wdata[D_W-1:0];
				CFG_INTERVAL:      interval_q       <= cfg_wdata[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wesm_front #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.pin_a              (pin_a),
		.pin_b              (pin_b),
		.time_now_us        (time_now_us),
		.update_interval_us (interval_q),
		.q_full             (q_full),
		.push               (push),
		.job                (push_job)
	);

	wesm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	wesm_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.ticks_per_rev      (ticks_per_rev_q),
		.wheel_diameter_mm  (wheel_diameter_q),
		.q_empty            (q_empty),
		.head               (head),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.window_distance_um (window_distance_um),
		.velocity_um_per_s  (velocity_um_per_s),
		.total_ticks        (total_ticks)
	);

endmodule

@@ sv/wesm_checker.sv @@
// ----------------------------------------------------------------------------
// Wheel encoder speed meter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wesm_checker import wesm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DIST_W-1:0] window_distance_um,
	input logic [VELO_W-1:0] velocity_um_per_s,
	input logic [31:0]       total_ticks
);

	// A stalled result beat keeps its value.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(window_distance_um) && $stable(velocity_um_per_s) && $stable(total_ticks))

	// No distance in the window means no velocity.
	`ASSERT_SAME(a_zero_dist, clk, arst_n, out_valid && window_distance_um == '0, velocity_um_per_s == '0)

	// Forward or empty windows never report a backward velocity.
	`ASSERT_SAME(a_sign_match, clk, arst_n, out_valid && !window_distance_um[DIST_W-1], !velocity_um_per_s[VELO_W-1])

	// Each result takes many cycles, so a taken beat is never followed at once.
	`ASSERT_NEXT(a_no_burst, clk, arst_n, out_valid && !out_stall, !out_valid)

endmodule

bind wheel_encoder_speed_meter_core wesm_checker u_wesm_checker (.*);
